### hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// Token kinds, scanner modes, character codes, keyword patterns and the
// record that carries finished tokens from the scanner to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   localparam int DEF_OFFSET_WIDTH  = 24;
   localparam int DEF_KEYWORD_CHARS = 6;
   localparam int DEF_LENGTH_WIDTH  = 16;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_TOKENS  = 3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_DOT,
      MODE_FRAC,
      MODE_BANG,
      MODE_EQ,
      MODE_HALT
   } mode_type;

   localparam logic [4:0] KIND_DOT     = 5'd5;
   localparam logic [4:0] KIND_BANG    = 5'd8;
   localparam logic [4:0] KIND_BANG_EQ = 5'd9;
   localparam logic [4:0] KIND_EQ      = 5'd10;
   localparam logic [4:0] KIND_EQ_EQ   = 5'd11;
   localparam logic [4:0] KIND_INT     = 5'd12;
   localparam logic [4:0] KIND_DEC     = 5'd13;
   localparam logic [4:0] KIND_TRUE    = 5'd14;
   localparam logic [4:0] KIND_FALSE   = 5'd15;
   localparam logic [4:0] KIND_FN      = 5'd16;
   localparam logic [4:0] KIND_LET     = 5'd17;
   localparam logic [4:0] KIND_RETURN  = 5'd18;
   localparam logic [4:0] KIND_IDENT   = 5'd19;
   localparam logic [4:0] KIND_EOF     = 5'd20;
   localparam logic [4:0] KIND_ERROR   = 5'd21;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_US    = 8'h5F;

   // Keywords packed with the first character in the lowest byte.
   localparam logic [63:0] KW_TRUE   = 64'h0000_0000_6575_7274;
   localparam logic [63:0] KW_FALSE  = 64'h0000_0065_736C_6166;
   localparam logic [63:0] KW_FN     = 64'h0000_0000_0000_6E66;
   localparam logic [63:0] KW_LET    = 64'h0000_0000_0074_656C;
   localparam logic [63:0] KW_RETURN = 64'h0000_6E72_7574_6572;

   localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
   localparam logic [30:0] INT_MAX  = 31'h7FFFFFFF;

   typedef struct packed {
      logic [4:0]  kind;
      logic [23:0] start;
      logic [15:0] len;
      logic [23:0] line;
      logic [30:0] intv;
      logic [29:0] frac;
      logic [7:0]  fdig;
      logic        ovf;
      logic        last;
   } tok_type;

   // Tokens produced by one accepted item, in emission order.
   typedef struct packed {
      logic [1:0]                   count;
      tok_type [MAX_TOKENS-1:0]     toks;
   } wr_type;

   // Punctuator lookup: bit 3 set when the byte is one, index in the low bits.
   function automatic logic [3:0] punct_code(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         8'h28: r = 4'b1000;
         8'h29: r = 4'b1001;
         8'h7B: r = 4'b1010;
         8'h7D: r = 4'b1011;
         8'h2C: r = 4'b1100;
         8'h2E: r = 4'b1101;
         8'h3B: r = 4'b1110;
         8'h3A: r = 4'b1111;
         default: r = 4'b0000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// source_token_scanner_core: streaming lexical scanner
// Turns a stream of source bytes, closed by an end-of-file item, into tokens
// with kind, start offset, length, line and number values.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Transfer carries
//   --------+-----------+-------------------------------------------------
//   req_*   | in        | one source byte, or end of file (req_tuser)
//   rsp_*   | out       | one token; rsp_tlast marks the last of an item
//
// Each byte is scanned in the cycle of its transfer: the mode and the
// accumulators (with a constant multiply by ten) update together, so one
// byte can be taken every clock. The scanner writes zero to three tokens per
// byte into an eight-entry queue, which sends one token per clock unless
// rsp_tready is low. Bytes are taken while the queue has room for three more
// tokens, so a long run of tokens from consecutive bytes throttles input to
// the output rate. The synchronous reset returns the scanner to its
// start-of-file state and empties the queue; an end-of-file item does the
// same to the scan state.
`default_nettype none

module source_token_scanner_core #(
   parameter int OFFSET_WIDTH  = sts_pkg::DEF_OFFSET_WIDTH,
   parameter int KEYWORD_CHARS = sts_pkg::DEF_KEYWORD_CHARS,
   parameter int LENGTH_WIDTH  = sts_pkg::DEF_LENGTH_WIDTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_byte
   input  wire logic         req_tuser,   // [0] opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [23:0] start_offset, [39:24] token_length, [63:40] line_number,
   // [94:64] int_value, [124:95] frac_value, [132:125] frac_digits,
   // [133] overflow, [135:134] zero
   output logic [135:0]      rsp_tdata,
   output logic [4:0]        rsp_tuser,   // [4:0] token_kind
   output logic              rsp_tlast
);
   import sts_pkg::*;

   wr_type             wr;
   tok_type            tok;
   logic               fire;
   logic [QLVL_W-1:0]  level;

   assign fire = req_tvalid && req_tready;

   // Front: classifies each byte and builds the tokens.
   sts_front #(
      .OFFSET_WIDTH  (OFFSET_WIDTH),
      .KEYWORD_CHARS (KEYWORD_CHARS),
      .LENGTH_WIDTH  (LENGTH_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .opcode    (req_tuser),
      .char_byte (req_tdata),
      .wr        (wr)
   );

   // Back: queues the tokens and sends them one per transfer.
   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .in_ready  (req_tready),
      .out_tok   (tok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .level     (level)
   );

   assign rsp_tuser = tok.kind;
   assign rsp_tlast = tok.last;
   assign rsp_tdata = {2'b00, tok.ovf, tok.fdig, tok.frac, tok.intv,
                       tok.line, tok.len, tok.start};

   // The queue never holds more tokens than it has entries.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= QLVL_W'(QUEUE_DEPTH))
      else $error("token queue over its depth");

   // Tokens are produced only for an item taken in that cycle.
   a_write_on_fire: assert property (@(posedge clock) disable iff (reset)
      (wr.count != 2'd0) |-> fire)
      else $error("token written without an input transfer");

   // An end of file always leaves at least its eof token to send.
   a_eof_output: assert property (@(posedge clock) disable iff (reset)
      (fire && req_tuser) |=> rsp_tvalid)
      else $error("no token queued after end of file");

   // The last token of each item carries the end mark.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (wr.count != 2'd0) |-> wr.toks[wr.count - 2'd1].last)
      else $error("final token of an item not marked");

endmodule

`default_nettype wire

### hdl/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front: byte classifier and token builder
// Takes one byte or end-of-file item per transfer, updates the scan state
// and hands up to three finished tokens to the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front #(
   parameter int OFFSET_WIDTH  = sts_pkg::DEF_OFFSET_WIDTH,
   parameter int KEYWORD_CHARS = sts_pkg::DEF_KEYWORD_CHARS,
   parameter int LENGTH_WIDTH  = sts_pkg::DEF_LENGTH_WIDTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           fire,
   input  wire logic           opcode,
   input  wire logic [7:0]     char_byte,
   output sts_pkg::wr_type     wr
);
   import sts_pkg::*;

   localparam int OW = OFFSET_WIDTH;
   localparam int LW = LENGTH_WIDTH;
   localparam int KW = 8 * KEYWORD_CHARS;
   localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

   mode_type      mode_ff, mode_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic [OW-1:0] start_ff, start_in;
   logic [23:0]   line_ff, line_in;
   logic [30:0]   int_ff, int_in;
   logic [29:0]   frac_ff, frac_in;
   logic [7:0]    fcnt_ff, fcnt_in;
   logic [KW-1:0] kw_ff, kw_in;
   logic [LW-1:0] len_ff, len_in;
   logic          sat_ff, sat_in;

   tok_type    fl_a, fl_b, fr, fc;
   logic       fl_a_v, fl_b_v, fr_v, fc_v, use_flush, handled;
   logic [4:0] id_kind;
   logic [3:0] pc, dval;
   logic       is_dig, is_let, is_blank;
   logic [34:0] int_prod;
   logic [33:0] frac_prod;
   logic [1:0]  k;

   function automatic logic [23:0] off24(input logic [OW-1:0] v);
      logic [OW+23:0] t;
      t = {24'd0, v};
      return t[23:0];
   endfunction

   function automatic logic [15:0] len16(input logic [LW-1:0] v);
      logic [LW+15:0] t;
      t = {16'd0, v};
      return t[15:0];
   endfunction

   assign is_dig   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
   assign is_let   = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                     ((char_byte >= 8'h41) && (char_byte <= 8'h5A));
   assign is_blank = (char_byte == CH_SPACE) || (char_byte == CH_CR) ||
                     (char_byte == CH_TAB);
   assign dval     = char_byte[3:0];
   assign pc       = punct_code(char_byte);
   assign int_prod = {4'd0, int_ff} * 35'd10 + {31'd0, dval};
   assign frac_prod = {4'd0, frac_ff} * 34'd10 + {30'd0, dval};

   // Keyword match on the collected characters and the length.
   always_comb begin
      id_kind = KIND_IDENT;
      if (len_ff == LW'(4) && kw_ff == KW_TRUE[KW-1:0]) begin
         id_kind = KIND_TRUE;
      end else if (len_ff == LW'(5) && kw_ff == KW_FALSE[KW-1:0]) begin
         id_kind = KIND_FALSE;
      end else if (len_ff == LW'(2) && kw_ff == KW_FN[KW-1:0]) begin
         id_kind = KIND_FN;
      end else if (len_ff == LW'(3) && kw_ff == KW_LET[KW-1:0]) begin
         id_kind = KIND_LET;
      end else if (len_ff == LW'(6) && kw_ff == KW_RETURN[KW-1:0]) begin
         id_kind = KIND_RETURN;
      end
   end

   // Tokens that the pending scan state produces when it is closed.
   always_comb begin
      fl_a   = '0;
      fl_b   = '0;
      fl_a_v = 1'b0;
      fl_b_v = 1'b0;
      fl_a.start = off24(start_ff);
      fl_a.len   = len16(len_ff);
      fl_a.line  = line_ff;
      fl_a.ovf   = sat_ff;
      case (mode_ff)
         MODE_IDENT: begin
            fl_a_v    = 1'b1;
            fl_a.kind = id_kind;
         end
         MODE_INT: begin
            fl_a_v    = 1'b1;
            fl_a.kind = KIND_INT;
            fl_a.intv = int_ff;
         end
         MODE_DOT: begin
            fl_a_v     = 1'b1;
            fl_a.kind  = KIND_INT;
            fl_a.intv  = int_ff;
            fl_b_v     = 1'b1;
            fl_b.kind  = KIND_DOT;
            fl_b.start = off24(pos_ff - OW'(1));
            fl_b.len   = 16'd1;
            fl_b.line  = line_ff;
         end
         MODE_FRAC: begin
            fl_a_v    = 1'b1;
            fl_a.kind = KIND_DEC;
            fl_a.intv = int_ff;
            fl_a.frac = frac_ff;
            fl_a.fdig = fcnt_ff;
         end
         MODE_BANG: begin
            fl_a_v    = 1'b1;
            fl_a.kind = KIND_BANG;
            fl_a.len  = 16'd1;
            fl_a.ovf  = 1'b0;
         end
         MODE_EQ: begin
            fl_a_v    = 1'b1;
            fl_a.kind = KIND_EQ;
            fl_a.len  = 16'd1;
            fl_a.ovf  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Single-byte token for a byte that the current scan mode does not take.
   always_comb begin
      fr       = '0;
      fr.start = off24(pos_ff);
      fr.len   = 16'd1;
      fr.line  = line_ff;
      fr_v     = 1'b0;
      if (is_blank || char_byte == CH_LF) begin
         fr_v = 1'b0;
      end else if (pc[3]) begin
         fr_v    = 1'b1;
         fr.kind = {2'b00, pc[2:0]};
      end else if (char_byte == CH_BANG || char_byte == CH_EQ || is_dig || is_let ||
                   char_byte == CH_US) begin
         fr_v = 1'b0;
      end else begin
         fr_v    = 1'b1;
         fr.kind = KIND_ERROR;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      line_in   = line_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      fcnt_in   = fcnt_ff;
      kw_in     = kw_ff;
      len_in    = len_ff;
      sat_in    = sat_ff;
      handled   = 1'b0;
      use_flush = 1'b0;
      fc        = '0;
      fc_v      = 1'b0;
      if (fire) begin
         if (opcode == OP_EOF) begin
            use_flush = 1'b1;
            fc_v      = 1'b1;
            fc.kind   = KIND_EOF;
            fc.start  = off24(pos_ff);
            fc.line   = line_ff;
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            start_in  = '0;
            line_in   = 24'd1;
            int_in    = '0;
            frac_in   = '0;
            fcnt_in   = '0;
            kw_in     = '0;
            len_in    = '0;
            sat_in    = 1'b0;
         end else begin
            pos_in = pos_ff + OW'(1);
            case (mode_ff)
               MODE_HALT: begin
                  handled = 1'b1;
               end
               MODE_IDENT: begin
                  if (is_let || is_dig) begin
                     for (int i = 0; i < KEYWORD_CHARS; i++) begin
                        if (len_ff == LW'(i)) begin
                           kw_in[8*i +: 8] = kw_ff[8*i +: 8] | char_byte;
                        end
                     end
                     if (len_in < LEN_MAX) len_in = len_in + LW'(1);
                     else sat_in = 1'b1;
                     handled = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (is_dig) begin
                     if (len_in < LEN_MAX) len_in = len_in + LW'(1);
                     else sat_in = 1'b1;
                     if (int_prod > {4'd0, INT_MAX}) begin
                        int_in = INT_MAX;
                        sat_in = 1'b1;
                     end else begin
                        int_in = int_prod[30:0];
                     end
                     handled = 1'b1;
                  end else if (char_byte == CH_DOT) begin
                     mode_in = MODE_DOT;
                     handled = 1'b1;
                  end
               end
               MODE_DOT, MODE_FRAC: begin
                  if (is_dig) begin
                     if (mode_ff == MODE_DOT) begin
                        if (len_in < LEN_MAX) len_in = len_in + LW'(1);
                        else sat_in = 1'b1;
                     end
                     if (len_in < LEN_MAX) len_in = len_in + LW'(1);
                     else sat_in = 1'b1;
                     if (fcnt_ff < 8'd9) frac_in = frac_prod[29:0];
                     if (fcnt_ff != 8'hFF) fcnt_in = fcnt_ff + 8'd1;
                     mode_in = MODE_FRAC;
                     handled = 1'b1;
                  end
               end
               MODE_BANG, MODE_EQ: begin
                  if (char_byte == CH_EQ) begin
                     fc_v     = 1'b1;
                     fc.kind  = (mode_ff == MODE_BANG) ? KIND_BANG_EQ : KIND_EQ_EQ;
                     fc.start = off24(start_ff);
                     fc.len   = 16'd2;
                     fc.line  = line_ff;
                     mode_in  = MODE_IDLE;
                     handled  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (!handled) begin
               use_flush = 1'b1;
               mode_in   = MODE_IDLE;
               fc        = fr;
               fc_v      = fr_v;
               if (char_byte == CH_LF && line_ff != LINE_MAX) begin
                  line_in = line_ff + 24'd1;
               end
               if (fr_v && fr.kind == KIND_ERROR) begin
                  mode_in = MODE_HALT;
               end
               if (char_byte == CH_BANG || char_byte == CH_EQ || is_dig || is_let ||
                   char_byte == CH_US) begin
                  start_in = pos_ff;
                  len_in   = LW'(1);
                  sat_in   = 1'b0;
                  int_in   = '0;
                  frac_in  = '0;
                  fcnt_in  = '0;
                  kw_in    = '0;
                  if (char_byte == CH_BANG) begin
                     mode_in = MODE_BANG;
                  end else if (char_byte == CH_EQ) begin
                     mode_in = MODE_EQ;
                  end else if (is_dig) begin
                     mode_in = MODE_INT;
                     int_in  = {27'd0, dval};
                  end else begin
                     mode_in = MODE_IDENT;
                     kw_in   = {{(KW-8){1'b0}}, char_byte};
                  end
               end
            end
         end
      end
   end

   // Pack the emitted tokens in order and flag the final one.
   always_comb begin
      wr = '0;
      k  = 2'd0;
      if (use_flush && fl_a_v) begin
         wr.toks[k] = fl_a;
         k = k + 2'd1;
      end
      if (use_flush && fl_b_v) begin
         wr.toks[k] = fl_b;
         k = k + 2'd1;
      end
      if (fc_v) begin
         wr.toks[k] = fc;
         k = k + 2'd1;
      end
      if (k != 2'd0) begin
         wr.toks[k - 2'd1].last = 1'b1;
      end
      wr.count = k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         line_ff  <= 24'd1;
         int_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         kw_ff    <= '0;
         len_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         line_ff  <= line_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         kw_ff    <= kw_in;
         len_ff   <= len_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue: token queue and output stage
// Stores up to three tokens per cycle and presents one token per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  sts_pkg::wr_type                 wr,
   output logic                            in_ready,
   output sts_pkg::tok_type                out_tok,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [sts_pkg::QLVL_W-1:0]      level
);
   import sts_pkg::*;

   tok_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QLVL_W-1:0]  lvl_ff, lvl_in;
   logic               pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (lvl_ff != '0);
   assign out_tok   = mem_ff[head_ff];
   assign in_ready  = (lvl_ff <= QLVL_W'(QUEUE_DEPTH - MAX_TOKENS));
   assign level     = lvl_ff;

   always_comb begin
      head_in = head_ff + QPTR_W'(pop);
      tail_in = tail_ff + QPTR_W'(wr.count);
      lvl_in  = lvl_ff + QLVL_W'(wr.count) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (wr.count > 2'(i)) begin
            mem_ff[tail_ff + QPTR_W'(i)] <= wr.toks[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         lvl_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         lvl_ff  <= lvl_in;
      end
   end

endmodule

`default_nettype wire
